// File: hw/rtl/kalc_pkg.sv
// ============================================================================
// kalc_pkg
// Shared types, key codes and decode functions for the keypad lock controller.
// ============================================================================
`default_nettype none

package kalc_pkg;

    localparam int unsigned KEY_W     = 8;
    localparam int unsigned CMD_W     = 4;
    localparam int unsigned AXIS_N    = 5;
    localparam int unsigned IDLE_W    = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_KEY   = 8'd1;

    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = 16'd1000;
    localparam logic [IDLE_W-1:0] IDLE_MAX         = 16'hFFFF;
    localparam logic [KEY_W-1:0]  MASTER_KEY_RST   = 8'h28;
    localparam logic [KEY_W-1:0]  KEY_NONE         = 8'h00;
    localparam logic [KEY_W-1:0]  KEY_LOCK_FIRST   = 8'h14;
    localparam logic [KEY_W-1:0]  KEY_LOCK_LAST    = 8'h18;

    localparam logic [2:0] AXIS_BED   = 3'd0;
    localparam logic [2:0] AXIS_BACK  = 3'd1;
    localparam logic [2:0] AXIS_LEG   = 3'd2;
    localparam logic [2:0] AXIS_PITCH = 3'd3;
    localparam logic [2:0] AXIS_ROLL  = 3'd4;
    localparam logic [2:0] AXIS_NONE  = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [2:0]       axis;
    } t_motion;

    typedef struct packed {
        logic [KEY_W-1:0]  held_key;
        logic [AXIS_N-1:0] axis_lock_flags;
        logic              panel_unlocked;
        logic              tx_enable;
        logic [CMD_W-1:0]  cmd_code;
        logic              cmd_valid;
    } t_result;

    function automatic t_motion motion_decode(input logic [KEY_W-1:0] key);
        t_motion m;
        m.axis = AXIS_NONE;
        m.cmd  = 4'd0;
        case (key)
            8'h09: begin m.axis = AXIS_BED;   m.cmd = 4'd1;  end
            8'h19: begin m.axis = AXIS_BED;   m.cmd = 4'd2;  end
            8'h10: begin m.axis = AXIS_BACK;  m.cmd = 4'd3;  end
            8'h20: begin m.axis = AXIS_BACK;  m.cmd = 4'd4;  end
            8'h11: begin m.axis = AXIS_LEG;   m.cmd = 4'd5;  end
            8'h21: begin m.axis = AXIS_LEG;   m.cmd = 4'd6;  end
            8'h12: begin m.axis = AXIS_PITCH; m.cmd = 4'd8;  end
            8'h22: begin m.axis = AXIS_PITCH; m.cmd = 4'd7;  end
            8'h13: begin m.axis = AXIS_ROLL;  m.cmd = 4'd9;  end
            8'h23: begin m.axis = AXIS_ROLL;  m.cmd = 4'd10; end
            8'h24: m.cmd = 4'd11;
            8'h25: m.cmd = 4'd12;
            8'h26: m.cmd = 4'd13;
            8'h27: m.cmd = 4'd14;
            default: m.cmd = 4'd0;
        endcase
        return m;
    endfunction

    function automatic logic axis_free(input logic [2:0] axis,
                                       input logic [AXIS_N-1:0] locks);
        logic f;
        f = 1'b1;
        case (axis)
            AXIS_BED:   f = ~locks[0];
            AXIS_BACK:  f = ~locks[1];
            AXIS_LEG:   f = ~locks[2];
            AXIS_PITCH: f = ~locks[3];
            AXIS_ROLL:  f = ~locks[4];
            default:    f = 1'b1;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/kalc_step.sv
// ============================================================================
// kalc_step
// Lock state, configuration registers and the per-tick decode and update.
// ============================================================================
`default_nettype none

module kalc_step
    import kalc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 i_adv,
    input  wire logic [KEY_W-1:0]     i_key,
    input  wire logic [KEY_W-1:0]     i_mc,
    output t_result                   o_res
);

    logic [IDLE_W-1:0] r_idle_timeout;
    logic [KEY_W-1:0]  r_master_key;
    logic              r_unlocked,  n_unlocked;
    logic              r_await,     n_await;
    logic [KEY_W-1:0]  r_held,      n_held;
    logic [IDLE_W-1:0] r_idle,      n_idle;
    logic [AXIS_N-1:0] r_locks,     n_locks;

    t_motion           held_m;
    t_motion           key_m;
    logic [IDLE_W-1:0] idle_inc;
    logic [2:0]        lock_idx;
    logic              is_lock_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= IDLE_TIMEOUT_RST;
            r_master_key   <= MASTER_KEY_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDLE_TIMEOUT) begin
                r_idle_timeout <= i_cfg_data;
            end else if (i_cfg_index == CFG_MASTER_KEY) begin
                r_master_key <= i_cfg_data[KEY_W-1:0];
            end
        end
    end

    assign held_m      = motion_decode(r_held);
    assign key_m       = motion_decode(i_key);
    assign idle_inc    = (r_idle != IDLE_MAX) ? r_idle + 16'd1 : r_idle;
    assign lock_idx    = i_key[2:0] - 3'd4;
    assign is_lock_key = (i_key >= KEY_LOCK_FIRST) && (i_key <= KEY_LOCK_LAST);

    always_comb begin
        n_unlocked = r_unlocked;
        n_await    = r_await;
        n_held     = r_held;
        n_idle     = r_idle;
        n_locks    = r_locks;
        o_res      = '0;

        if (!r_unlocked) begin
            if (r_await) begin
                if (i_key == KEY_NONE) begin
                    n_await = 1'b0;
                    n_held  = KEY_NONE;
                end
            end else if (i_mc != KEY_NONE && i_mc == r_master_key) begin
                n_unlocked = 1'b1;
                n_await    = 1'b1;
                n_held     = KEY_NONE;
                n_idle     = '0;
            end
        end else if (r_await) begin
            if (r_held == KEY_NONE) begin
                if (i_mc == KEY_NONE) begin
                    n_await = 1'b0;
                end
            end else if (i_key == KEY_NONE) begin
                n_await = 1'b0;
                n_held  = KEY_NONE;
            end else if (held_m.cmd != 4'd0) begin
                o_res.tx_enable = 1'b1;
                o_res.held_key  = r_held;
                if (axis_free(held_m.axis, r_locks)) begin
                    o_res.cmd_valid = 1'b1;
                    o_res.cmd_code  = held_m.cmd;
                end
            end
        end else begin
            if (i_key != KEY_NONE && i_key == r_master_key) begin
                n_locks    = '0;
                n_unlocked = 1'b0;
                n_await    = 1'b1;
                n_held     = i_key;
                n_idle     = '0;
            end else if (key_m.cmd != 4'd0) begin
                n_idle          = '0;
                n_await         = 1'b1;
                n_held          = i_key;
                o_res.tx_enable = 1'b1;
                o_res.held_key  = i_key;
                if (axis_free(key_m.axis, r_locks)) begin
                    o_res.cmd_valid = 1'b1;
                    o_res.cmd_code  = key_m.cmd;
                end
            end else if (is_lock_key) begin
                n_locks = r_locks ^ (AXIS_N'(1) << lock_idx);
                n_idle  = '0;
                n_await = 1'b1;
                n_held  = i_key;
            end else begin
                n_idle = idle_inc;
                if (idle_inc > r_idle_timeout) begin
                    n_locks    = '0;
                    n_unlocked = 1'b0;
                    n_idle     = '0;
                end
            end
        end

        o_res.panel_unlocked  = n_unlocked;
        o_res.axis_lock_flags = n_locks;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlocked <= 1'b0;
            r_await    <= 1'b0;
            r_held     <= KEY_NONE;
            r_idle     <= '0;
            r_locks    <= '0;
        end else if (i_adv) begin
            r_unlocked <= n_unlocked;
            r_await    <= n_await;
            r_held     <= n_held;
            r_idle     <= n_idle;
            r_locks    <= n_locks;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/keypad_axis_lock_controller.sv
// ============================================================================
// keypad_axis_lock_controller
// Keypad scan stream in, one motion/lock status transaction out per scan tick.
// ============================================================================
//  channel   direction  handshake                 payload
//  s_axis    in         i_s_axis_tvalid/tready    tdata: key_code, master_code
//  m_axis    out        o_m_axis_tvalid/tready    tdata: status and command
//  cfg       in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
//  One transaction per cycle sustained while the output is not stalled;
//  path: input register, then decode and state update into the output register.
//  i_rst_n is synchronous, active low: panel locked, all axes free, config
//  back to defaults. A stalled output holds the result; the input register
//  keeps taking ticks while the output stage has room.
// ============================================================================
`default_nettype none

module keypad_axis_lock_controller
    import kalc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [7:0] key_code, [15:8] master_code
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [0] cmd_valid, [4:1] cmd_code, [5] tx_enable, [6] panel_unlocked,
    // [11:7] axis_lock_flags, [19:12] held_key, [23:20] zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data
);

    logic                 r_in_vld;
    logic [KEY_W-1:0]     r_key;
    logic [KEY_W-1:0]     r_mc;
    logic                 r_out_vld;
    t_result              r_res;
    t_result              step_res;
    logic                 out_free;
    logic                 adv;
    logic                 in_free;

    assign out_free = ~r_out_vld | i_m_axis_tready;
    assign adv      = r_in_vld & out_free;
    assign in_free  = ~r_in_vld | adv;

    assign o_s_axis_tready = in_free;
    assign o_cfg_ready     = 1'b1;

    kalc_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (adv),
        .i_key       (r_key),
        .i_mc        (r_mc),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_free) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_s_axis_tvalid) begin
            r_key <= i_s_axis_tdata[KEY_W-1:0];
            r_mc  <= i_s_axis_tdata[2*KEY_W-1:KEY_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= step_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {(OUT_DATA_W - $bits(t_result))'(0), r_res};

endmodule

`default_nettype wire

// File: tb/kalc_status_checker.sv
// ----------------------------------------------------------------------------
// kalc_status_checker
// Watches the scan, status and register channels of the keypad lock
// controller, predicts one status transaction per accepted scan tick and
// compares every status transaction field by field, oldest first.
// ----------------------------------------------------------------------------
module kalc_status_checker
    import kalc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    input  wire logic                  i_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                  i_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data,
    output int                         o_pending,
    output int                         o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STATUS_W  = $bits(t_result);

    localparam logic [KEY_W-1:0] KEY_BED_A   = 8'h09;
    localparam logic [KEY_W-1:0] KEY_BED_B   = 8'h19;
    localparam logic [KEY_W-1:0] KEY_BACK_A  = 8'h10;
    localparam logic [KEY_W-1:0] KEY_BACK_B  = 8'h20;
    localparam logic [KEY_W-1:0] KEY_LEG_A   = 8'h11;
    localparam logic [KEY_W-1:0] KEY_LEG_B   = 8'h21;
    localparam logic [KEY_W-1:0] KEY_PITCH_A = 8'h12;
    localparam logic [KEY_W-1:0] KEY_PITCH_B = 8'h22;
    localparam logic [KEY_W-1:0] KEY_ROLL_A  = 8'h13;
    localparam logic [KEY_W-1:0] KEY_ROLL_B  = 8'h23;
    localparam logic [KEY_W-1:0] KEY_AUX_A   = 8'h24;
    localparam logic [KEY_W-1:0] KEY_AUX_B   = 8'h25;
    localparam logic [KEY_W-1:0] KEY_AUX_C   = 8'h26;
    localparam logic [KEY_W-1:0] KEY_AUX_D   = 8'h27;

    logic [IDLE_W-1:0] idle_limit;
    logic [KEY_W-1:0]  master_key;
    logic              panel_open;
    logic              release_wait;
    logic [KEY_W-1:0]  held_code;
    logic [IDLE_W-1:0] idle_ticks;
    logic [AXIS_N-1:0] axis_locks;
    t_result           expected_status_q[$];
    int                pending_count = 0;
    int                mismatch_count = 0;

    assign o_pending    = pending_count;
    assign o_mismatches = mismatch_count;

    function automatic logic [CMD_W-1:0] motion_command(input logic [KEY_W-1:0] key,
                                                        output logic [2:0] axis);
        logic [CMD_W-1:0] c;
        c    = '0;
        axis = AXIS_NONE;
        case (key)
            KEY_BED_A:   begin axis = AXIS_BED;   c = 4'd1;  end
            KEY_BED_B:   begin axis = AXIS_BED;   c = 4'd2;  end
            KEY_BACK_A:  begin axis = AXIS_BACK;  c = 4'd3;  end
            KEY_BACK_B:  begin axis = AXIS_BACK;  c = 4'd4;  end
            KEY_LEG_A:   begin axis = AXIS_LEG;   c = 4'd5;  end
            KEY_LEG_B:   begin axis = AXIS_LEG;   c = 4'd6;  end
            KEY_PITCH_A: begin axis = AXIS_PITCH; c = 4'd8;  end
            KEY_PITCH_B: begin axis = AXIS_PITCH; c = 4'd7;  end
            KEY_ROLL_A:  begin axis = AXIS_ROLL;  c = 4'd9;  end
            KEY_ROLL_B:  begin axis = AXIS_ROLL;  c = 4'd10; end
            KEY_AUX_A:   c = 4'd11;
            KEY_AUX_B:   c = 4'd12;
            KEY_AUX_C:   c = 4'd13;
            KEY_AUX_D:   c = 4'd14;
            default:     c = '0;
        endcase
        return c;
    endfunction

    // tx and held key follow the key; the command itself only on a free axis
    function automatic t_result motion_status(input logic [KEY_W-1:0] key);
        t_result          r;
        logic [CMD_W-1:0] c;
        logic [2:0]       ax;
        r = '0;
        c = motion_command(key, ax);
        if (c != '0) begin
            r.tx_enable = 1'b1;
            r.held_key  = key;
            if (ax == AXIS_NONE || !axis_locks[ax]) begin
                r.cmd_valid = 1'b1;
                r.cmd_code  = c;
            end
        end
        return r;
    endfunction

    task automatic predict_scan_tick(input logic [KEY_W-1:0] key,
                                     input logic [KEY_W-1:0] mc,
                                     output t_result r);
        logic [CMD_W-1:0] c;
        logic [2:0]       ax;
        r = '0;
        if (!panel_open) begin
            if (release_wait) begin
                if (key == KEY_NONE) begin
                    release_wait = 1'b0;
                    held_code    = KEY_NONE;
                end
            end else if (mc != KEY_NONE && mc == master_key) begin
                panel_open   = 1'b1;
                release_wait = 1'b1;
                held_code    = KEY_NONE;
                idle_ticks   = '0;
            end
        end else if (release_wait) begin
            if (held_code == KEY_NONE) begin
                if (mc == KEY_NONE)
                    release_wait = 1'b0;
            end else if (key == KEY_NONE) begin
                release_wait = 1'b0;
                held_code    = KEY_NONE;
            end else begin
                r = motion_status(held_code);
            end
        end else begin
            c = motion_command(key, ax);
            if (key != KEY_NONE && key == master_key) begin
                axis_locks   = '0;
                panel_open   = 1'b0;
                release_wait = 1'b1;
                held_code    = key;
                idle_ticks   = '0;
            end else if (c != '0) begin
                r            = motion_status(key);
                idle_ticks   = '0;
                release_wait = 1'b1;
                held_code    = key;
            end else if (key >= KEY_LOCK_FIRST && key <= KEY_LOCK_LAST) begin
                axis_locks   = axis_locks ^ (AXIS_N'(1) << (key - KEY_LOCK_FIRST));
                idle_ticks   = '0;
                release_wait = 1'b1;
                held_code    = key;
            end else begin
                if (idle_ticks != IDLE_MAX)
                    idle_ticks = idle_ticks + 1'b1;
                if (idle_ticks > idle_limit) begin
                    axis_locks = '0;
                    panel_open = 1'b0;
                    idle_ticks = '0;
                end
            end
        end
        r.panel_unlocked  = panel_open;
        r.axis_lock_flags = axis_locks;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("%0t: status %s mismatch: got 0x%0h, expected 0x%0h",
                 $time, what, got_v, want_v);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            idle_limit   = IDLE_TIMEOUT_RST;
            master_key   = MASTER_KEY_RST;
            panel_open   = 1'b0;
            release_wait = 1'b0;
            held_code    = KEY_NONE;
            idle_ticks   = '0;
            axis_locks   = '0;
            expected_status_q.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = i_m_axis_tdata[STATUS_W-1:0];
                if (expected_status_q.size() == 0) begin
                    report_mismatch("transaction (none expected)", 32'(i_m_axis_tdata), '0);
                end else begin
                    want = expected_status_q.pop_front();
                    if (got.cmd_valid != want.cmd_valid)
                        report_mismatch("cmd_valid", 32'(got.cmd_valid),
                                        32'(want.cmd_valid));
                    if (got.cmd_code != want.cmd_code)
                        report_mismatch("cmd_code", 32'(got.cmd_code), 32'(want.cmd_code));
                    if (got.tx_enable != want.tx_enable)
                        report_mismatch("tx_enable", 32'(got.tx_enable),
                                        32'(want.tx_enable));
                    if (got.panel_unlocked != want.panel_unlocked)
                        report_mismatch("panel_unlocked", 32'(got.panel_unlocked),
                                        32'(want.panel_unlocked));
                    if (got.axis_lock_flags != want.axis_lock_flags)
                        report_mismatch("axis_lock_flags", 32'(got.axis_lock_flags),
                                        32'(want.axis_lock_flags));
                    if (got.held_key != want.held_key)
                        report_mismatch("held_key", 32'(got.held_key), 32'(want.held_key));
                end
                if (i_m_axis_tdata[OUT_DATA_W-1:STATUS_W] != '0)
                    report_mismatch("pad bits", 32'(i_m_axis_tdata[OUT_DATA_W-1:STATUS_W]),
                                    '0);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDLE_TIMEOUT: idle_limit = i_cfg_data[IDLE_W-1:0];
                    CFG_MASTER_KEY:   master_key = i_cfg_data[KEY_W-1:0];
                    default:          ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                predict_scan_tick(i_s_axis_tdata[KEY_W-1:0],
                                  i_s_axis_tdata[2*KEY_W-1:KEY_W], want);
                expected_status_q.push_back(want);
            end
        end
        pending_count = expected_status_q.size();
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives keypad scan ticks into the lock controller in bursts: a short
// directed run through unlock, hold, axis locks, idle relock and key relock,
// then random key sequences under several register settings and an idle
// stretch under the largest timeout. The status side stalls on its own
// pattern; the checker predicts and compares every status transaction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kalc_pkg::*;

    localparam logic [KEY_W-1:0] KEY_BED_A    = 8'h09;
    localparam logic [KEY_W-1:0] KEY_AUX_D    = 8'h27;
    localparam logic [KEY_W-1:0] KEY_UNMAPPED = 8'h01;
    localparam logic [KEY_W-1:0] KEY_ALL_ONES = 8'hFF;
    localparam logic [KEY_W-1:0] KEY_SPAN_LO  = 8'h08;

    localparam int PHASES       = 8;
    localparam int PHASE_TICKS  = 245;
    localparam int IDLE_RUN     = 60;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;
    int                    pending;
    int                    mismatches;

    logic [KEY_W-1:0]      master_key_now = MASTER_KEY_RST;
    int                    burst_left = 0;
    bit                    steady = 1'b0;
    int                    ticks_sent = 0;

    keypad_axis_lock_controller i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    kalc_status_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_pending       (pending),
        .o_mismatches    (mismatches)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // status side: own stall pattern, plus a long hold-off now and then
    initial begin : status_stall
        int mode;
        int span;
        int since_hold;
        since_hold = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                since_hold++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= since_hold[0];
                endcase
                @(posedge clk);
            end
            if (since_hold >= 700) begin
                m_tready <= 1'b0;
                repeat (80) @(posedge clk);
                since_hold = 0;
            end
        end
    end

    task automatic scan_tick(input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] mc);
        int gap;
        if (!steady && burst_left <= 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mc, key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        ticks_sent++;
    endtask

    task automatic wait_all_status();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic set_registers(input logic [IDLE_W-1:0] timeout,
                                 input logic [KEY_W-1:0] master);
        write_register(CFG_IDLE_TIMEOUT, timeout);
        write_register(CFG_MASTER_KEY, {8'($urandom), master});
        cfg_valid <= 1'b0;
        master_key_now = master;
    endtask

    function automatic logic [KEY_W-1:0] master_noise();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom) : KEY_NONE;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(KEY_SPAN_LO, MASTER_KEY_RST));
    endfunction

    task automatic key_sequence(input logic [KEY_W-1:0] key, input int hold);
        int i;
        scan_tick(key, master_noise());
        for (i = 1; i < hold; i++)
            scan_tick(($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : key,
                      master_noise());
        scan_tick(KEY_NONE, ($urandom_range(0, 5) == 0) ? master_noise() : KEY_NONE);
    endtask

    task automatic unlock_sequence();
        scan_tick(KEY_NONE, KEY_NONE);
        repeat ($urandom_range(1, 3))
            scan_tick(($urandom_range(0, 2) == 0) ? 8'($urandom) : KEY_NONE, master_key_now);
        scan_tick(KEY_NONE, KEY_NONE);
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            unlock_sequence();
        end else if (pick < 60) begin
            key_sequence(pick_key(), $urandom_range(1, 6));
        end else if (pick < 75) begin
            repeat ($urandom_range(1, 48))
                scan_tick(($urandom_range(0, 3) == 0) ?
                          8'($urandom_range(MASTER_KEY_RST + 1, 255)) : KEY_NONE,
                          master_noise());
        end else if (pick < 82) begin
            key_sequence(master_key_now, 1);
        end else begin
            repeat ($urandom_range(1, 4)) scan_tick(8'($urandom), 8'($urandom));
        end
    endtask

    initial begin : stimulus
        int phase;
        int phase_end;
        logic [IDLE_W-1:0] timeout;
        logic [KEY_W-1:0]  master;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        set_registers(IDLE_W'(3), MASTER_KEY_RST);

        // locked: a foreign master code does nothing, then unlock and hold
        scan_tick(KEY_AUX_D, KEY_ALL_ONES);
        scan_tick(KEY_NONE, master_key_now);
        scan_tick(KEY_ALL_ONES, master_key_now);
        scan_tick(KEY_NONE, KEY_NONE);
        scan_tick(KEY_BED_A, KEY_NONE);
        scan_tick(KEY_ALL_ONES, KEY_ALL_ONES);
        scan_tick(KEY_NONE, KEY_NONE);
        // lock the bed axis, then press a bed key on the locked axis
        scan_tick(KEY_LOCK_FIRST, KEY_NONE);
        scan_tick(KEY_NONE, KEY_NONE);
        scan_tick(KEY_BED_A, KEY_NONE);
        scan_tick(KEY_NONE, KEY_NONE);
        scan_tick(KEY_AUX_D, KEY_NONE);
        scan_tick(KEY_NONE, KEY_NONE);
        scan_tick(KEY_LOCK_LAST, KEY_NONE);
        scan_tick(KEY_NONE, KEY_NONE);
        // idle past the timeout, unmapped key included
        scan_tick(KEY_UNMAPPED, KEY_NONE);
        repeat (3) scan_tick(KEY_NONE, KEY_NONE);
        // unlock again, relock by key, master ignored until key release
        scan_tick(KEY_NONE, master_key_now);
        scan_tick(KEY_NONE, KEY_NONE);
        scan_tick(master_key_now, KEY_NONE);
        scan_tick(master_key_now, master_key_now);
        scan_tick(KEY_NONE, master_key_now);
        scan_tick(KEY_NONE, master_key_now);
        scan_tick(KEY_NONE, KEY_NONE);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_all_status();
            case (phase)
                0: begin timeout = '0; master = MASTER_KEY_RST; end
                1: begin timeout = IDLE_MAX; master = KEY_ALL_ONES; end
                2: begin timeout = IDLE_W'($urandom_range(1, 30)); master = KEY_NONE; end
                3: begin
                    timeout = IDLE_W'($urandom_range(1, 30));
                    master  = 8'($urandom_range(KEY_SPAN_LO, MASTER_KEY_RST));
                end
                4: begin timeout = IDLE_TIMEOUT_RST; master = MASTER_KEY_RST; end
                default: begin
                    timeout = ($urandom_range(0, 3) == 0) ? IDLE_W'($urandom) :
                              IDLE_W'($urandom_range(0, 40));
                    master  = ($urandom_range(0, 1) == 0) ? MASTER_KEY_RST :
                              8'($urandom_range(1, 255));
                end
            endcase
            set_registers(timeout, master);
            phase_end = ticks_sent + ((phase == 2) ? PHASE_TICKS / 4 : PHASE_TICKS);
            while (ticks_sent < phase_end)
                random_sequence();
        end

        // idle run under the largest timeout, which never relocks
        wait_all_status();
        set_registers(IDLE_MAX, MASTER_KEY_RST);
        steady = 1'b1;
        unlock_sequence();
        repeat (IDLE_RUN) scan_tick(KEY_NONE, 8'($urandom));
        steady = 1'b0;
        key_sequence(KEY_BED_A, 2);

        wait_all_status();
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
